// ===== hdl/mpd_pkg.sv =====
// Shared types and constants for the mouse packet decoder.
`timescale 1ns / 1ps

package mpd_pkg;

    localparam int RX_BITS         = 8;
    localparam int CFG_BITS        = 12;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int HEADER_SYNC_BIT = 3;
    localparam int BTN_BITS        = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ENABLE = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_index;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_DX     = 4'b0010,
        PH_DY     = 4'b0100,
        PH_WHEEL  = 4'b1000
    } t_phase;

    typedef enum logic {
        KIND_POSITION = 1'b0,
        KIND_SCROLL   = 1'b1
    } t_update_kind;

endpackage

// ===== hdl/mouse_packet_decoder_top.sv =====
// Top level of the four-byte mouse packet decoder.
//
//   channel  dir  handshake            payload
//   rx byte  in   i_valid / o_stall    i_rx_byte
//   result   out  o_valid / i_stall    o_pos_x .. o_update_kind
//   config   in   i_cfg_we             i_cfg_index, i_cfg_data
//
// One byte per cycle unless the result side stalls. A byte is held in the input
// register, then its result (third/fourth bytes only) lands in the output register.
// Reset is synchronous and clears the framing phase, position, buttons and totals.
// A stalled result holds; one more byte is taken into the input register meanwhile.
`timescale 1ns / 1ps

module mouse_packet_decoder_top
    import mpd_pkg::*;
#(
    parameter int COORD_BITS  = 12,
    parameter int SCROLL_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  logic [CFG_BITS-1:0]           i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [RX_BITS-1:0]            i_rx_byte,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [COORD_BITS-1:0]         o_pos_x,
    output logic [COORD_BITS-1:0]         o_pos_y,
    output logic                          o_button_left,
    output logic                          o_button_right,
    output logic                          o_button_middle,
    output logic signed [SCROLL_BITS-1:0] o_wheel_x_total,
    output logic signed [SCROLL_BITS-1:0] o_wheel_y_total,
    output logic                          o_update_kind
);

    logic                   r_enable;
    logic [CFG_BITS-1:0]    r_width;
    logic [CFG_BITS-1:0]    r_height;

    logic                   r_in_valid;
    logic [RX_BITS-1:0]     r_in_byte;

    t_phase                 r_phase, n_phase;
    logic [RX_BITS-1:0]     r_header, n_header;
    logic [RX_BITS-1:0]     r_dx, n_dx;
    logic [COORD_BITS-1:0]  r_cur_x, n_cur_x;
    logic [COORD_BITS-1:0]  r_cur_y, n_cur_y;
    logic [BTN_BITS-1:0]    r_buttons, n_buttons;
    logic [SCROLL_BITS-1:0] r_scroll_h, n_scroll_h;
    logic [SCROLL_BITS-1:0] r_scroll_v, n_scroll_v;

    logic                   r_out_valid;
    t_update_kind           r_kind, n_kind;
    logic                   w_emit;

    logic                   w_out_blocked;
    logic                   w_fire;
    logic                   w_accept;
    logic [COORD_BITS-1:0]  w_clamp_x;
    logic [COORD_BITS-1:0]  w_clamp_y;
    logic [SCROLL_BITS-1:0] w_step;

    assign w_out_blocked = r_out_valid && i_stall;
    assign o_stall       = r_in_valid && w_out_blocked;
    assign w_accept      = i_valid && !o_stall;
    assign w_fire        = r_in_valid && !w_out_blocked;
    assign w_step        = SCROLL_BITS'($signed(r_in_byte));

    mpd_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_x (
        .i_cur      (r_cur_x),
        .i_delta    (r_dx),
        .i_subtract (1'b0),
        .i_limit    (r_width),
        .o_pos      (w_clamp_x)
    );

    mpd_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_y (
        .i_cur      (r_cur_y),
        .i_delta    (r_in_byte),
        .i_subtract (1'b1),
        .i_limit    (r_height),
        .o_pos      (w_clamp_y)
    );

    always_comb begin
        n_phase    = r_phase;
        n_header   = r_header;
        n_dx       = r_dx;
        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        n_buttons  = r_buttons;
        n_scroll_h = r_scroll_h;
        n_scroll_v = r_scroll_v;
        n_kind     = KIND_POSITION;
        w_emit     = 1'b0;
        if (r_enable) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_in_byte[HEADER_SYNC_BIT]) begin
                        n_header = r_in_byte;
                        n_phase  = PH_DX;
                    end
                end
                PH_DX: begin
                    n_dx    = r_in_byte;
                    n_phase = PH_DY;
                end
                PH_DY: begin
                    n_cur_x   = w_clamp_x;
                    n_cur_y   = w_clamp_y;
                    n_buttons = r_header[BTN_BITS-1:0];
                    n_phase   = PH_WHEEL;
                    n_kind    = KIND_POSITION;
                    w_emit    = 1'b1;
                end
                PH_WHEEL: begin
                    if (r_in_byte[0]) begin
                        n_scroll_v = r_scroll_v + w_step;
                    end else begin
                        n_scroll_h = r_scroll_h + w_step;
                    end
                    n_phase = PH_HEADER;
                    n_kind  = KIND_SCROLL;
                    w_emit  = 1'b1;
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_width  <= '0;
            r_height <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ENABLE: r_enable <= i_cfg_data[0];
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_header   <= '0;
            r_dx       <= '0;
            r_cur_x    <= '0;
            r_cur_y    <= '0;
            r_buttons  <= '0;
            r_scroll_h <= '0;
            r_scroll_v <= '0;
        end else if (w_fire) begin
            r_phase    <= n_phase;
            r_header   <= n_header;
            r_dx       <= n_dx;
            r_cur_x    <= n_cur_x;
            r_cur_y    <= n_cur_y;
            r_buttons  <= n_buttons;
            r_scroll_h <= n_scroll_h;
            r_scroll_v <= n_scroll_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_emit) begin
            o_pos_x         <= n_cur_x;
            o_pos_y         <= n_cur_y;
            o_button_left   <= n_buttons[0];
            o_button_right  <= n_buttons[1];
            o_button_middle <= n_buttons[2];
            o_wheel_x_total <= n_scroll_h;
            o_wheel_y_total <= n_scroll_v;
            r_kind          <= n_kind;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_update_kind = r_kind;

    a_result_from_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_in_valid))
        else $error("result appeared without a buffered request");

    a_held_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_out_blocked) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("buffered request lost while output blocked");

    a_wheel_follows_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_emit && (r_phase == PH_DY)) |=> (r_phase == PH_WHEEL))
        else $error("position update not followed by wheel phase");

endmodule

// ===== hdl/mpd_clamp.sv =====
// Pointer axis update: add or subtract a signed byte delta, clamp to 0..limit (limit capped at the COORD_BITS max).
`timescale 1ns / 1ps

module mpd_clamp
    import mpd_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic [COORD_BITS-1:0] i_cur,
    input  logic [RX_BITS-1:0]    i_delta,
    input  logic                  i_subtract,
    input  logic [CFG_BITS-1:0]   i_limit,
    output logic [COORD_BITS-1:0] o_pos
);

    localparam int LW = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 2;

    logic signed [LW-1:0] w_cur;
    logic signed [LW-1:0] w_delta;
    logic signed [LW-1:0] w_sum;
    logic signed [LW-1:0] w_limit;
    logic signed [LW-1:0] w_max;
    logic signed [LW-1:0] w_cap;
    logic signed [LW-1:0] w_res;

    assign w_cur   = LW'(i_cur);
    assign w_delta = LW'($signed(i_delta));
    assign w_sum   = i_subtract ? (w_cur - w_delta) : (w_cur + w_delta);
    assign w_limit = LW'(i_limit);
    assign w_max   = LW'({COORD_BITS{1'b1}});
    assign w_cap   = (w_limit > w_max) ? w_max : w_limit;

    always_comb begin
        if (w_sum < 0) begin
            w_res = '0;
        end else if (w_sum > w_cap) begin
            w_res = w_cap;
        end else begin
            w_res = w_sum;
        end
    end

    assign o_pos = w_res[COORD_BITS-1:0];

endmodule

// ===== bench/mpd_scoreboard.sv =====
// Scoreboard for the mouse packet decoder: mirrors the byte framing and checks every result.
`timescale 1ns / 1ps

module mpd_scoreboard
    import mpd_pkg::*;
#(
    parameter int COORD_BITS  = 12,
    parameter int SCROLL_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]       i_cfg_data,
    input  logic                      i_rx_valid,
    input  logic                      i_rx_stall,
    input  logic [RX_BITS-1:0]        i_rx_byte,
    input  logic                      i_res_valid,
    input  logic                      i_res_stall,
    input  logic [COORD_BITS-1:0]     i_pos_x,
    input  logic [COORD_BITS-1:0]     i_pos_y,
    input  logic                      i_button_left,
    input  logic                      i_button_right,
    input  logic                      i_button_middle,
    input  logic [SCROLL_BITS-1:0]    i_wheel_x_total,
    input  logic [SCROLL_BITS-1:0]    i_wheel_y_total,
    input  logic                      i_update_kind,
    output int                        o_mismatches,
    output int                        o_pending
);

    localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
    localparam int MAX_REPORTED = 10;

    typedef struct packed {
        logic [COORD_BITS-1:0]  pos_x;
        logic [COORD_BITS-1:0]  pos_y;
        logic                   btn_left;
        logic                   btn_right;
        logic                   btn_middle;
        logic [SCROLL_BITS-1:0] wheel_x;
        logic [SCROLL_BITS-1:0] wheel_y;
        t_update_kind           kind;
    } t_mouse_report;

    t_mouse_report reports_due[$];

    logic                   cfg_enable;
    logic [CFG_BITS-1:0]    cfg_width;
    logic [CFG_BITS-1:0]    cfg_height;

    t_phase                 frame_phase;
    logic [RX_BITS-1:0]     hdr_byte;
    logic [RX_BITS-1:0]     dx_byte;
    logic [COORD_BITS-1:0]  cur_x;
    logic [COORD_BITS-1:0]  cur_y;
    logic [BTN_BITS-1:0]    btn_state;
    logic [SCROLL_BITS-1:0] scroll_h;
    logic [SCROLL_BITS-1:0] scroll_v;

    int mismatch_count = 0;
    int pending_count  = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_count;

    function automatic logic [COORD_BITS-1:0] clamp_coord(int v, logic [CFG_BITS-1:0] limit);
        int lim;
        lim = int'(limit);
        if (lim > COORD_MAX) lim = COORD_MAX;
        if (v < 0) return '0;
        if (v > lim) return COORD_BITS'(lim);
        return COORD_BITS'(v);
    endfunction

    function automatic t_mouse_report make_report(t_update_kind kind);
        t_mouse_report r;
        r.pos_x      = cur_x;
        r.pos_y      = cur_y;
        r.btn_left   = btn_state[0];
        r.btn_right  = btn_state[1];
        r.btn_middle = btn_state[2];
        r.wheel_x    = scroll_h;
        r.wheel_y    = scroll_v;
        r.kind       = kind;
        return r;
    endfunction

    function automatic string report_text(t_mouse_report r);
        return $sformatf("x=%0d y=%0d l=%b r=%b m=%b wheel_x=%0d wheel_y=%0d kind=%0d",
            r.pos_x, r.pos_y, r.btn_left, r.btn_right, r.btn_middle,
            $signed(r.wheel_x), $signed(r.wheel_y), r.kind);
    endfunction

    task automatic decode_byte(input logic [RX_BITS-1:0] b);
        int                     nx;
        int                     ny;
        logic [SCROLL_BITS-1:0] step;
        if (!cfg_enable) return;
        case (frame_phase)
            PH_HEADER: begin
                if (b[HEADER_SYNC_BIT]) begin
                    hdr_byte    = b;
                    frame_phase = PH_DX;
                end
            end
            PH_DX: begin
                dx_byte     = b;
                frame_phase = PH_DY;
            end
            PH_DY: begin
                nx          = int'(cur_x) + int'($signed(dx_byte));
                ny          = int'(cur_y) - int'($signed(b));
                cur_x       = clamp_coord(nx, cfg_width);
                cur_y       = clamp_coord(ny, cfg_height);
                btn_state   = hdr_byte[BTN_BITS-1:0];
                frame_phase = PH_WHEEL;
                reports_due.push_back(make_report(KIND_POSITION));
            end
            PH_WHEEL: begin
                step = SCROLL_BITS'($signed(b));
                if (b[0]) scroll_v = scroll_v + step;
                else scroll_h = scroll_h + step;
                frame_phase = PH_HEADER;
                reports_due.push_back(make_report(KIND_SCROLL));
            end
            default: frame_phase = PH_HEADER;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_mouse_report got;
        t_mouse_report want;
        if (!i_rst_n) begin
            cfg_enable  = 1'b0;
            cfg_width   = '0;
            cfg_height  = '0;
            frame_phase = PH_HEADER;
            hdr_byte    = '0;
            dx_byte     = '0;
            cur_x       = '0;
            cur_y       = '0;
            btn_state   = '0;
            scroll_h    = '0;
            scroll_v    = '0;
            reports_due.delete();
        end else begin
            // check before decoding so a fresh request never pairs with an older result
            if (i_res_valid && !i_res_stall) begin
                got.pos_x      = i_pos_x;
                got.pos_y      = i_pos_y;
                got.btn_left   = i_button_left;
                got.btn_right  = i_button_right;
                got.btn_middle = i_button_middle;
                got.wheel_x    = i_wheel_x_total;
                got.wheel_y    = i_wheel_y_total;
                got.kind       = t_update_kind'(i_update_kind);
                if (reports_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTED)
                        $display("%0t: unexpected result %s", $time, report_text(got));
                end else begin
                    want = reports_due.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTED) begin
                            $display("%0t: result mismatch", $time);
                            $display("    expected %s", report_text(want));
                            $display("    actual   %s", report_text(got));
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ENABLE: cfg_enable = i_cfg_data[0];
                    CFG_WIDTH:  cfg_width  = i_cfg_data;
                    CFG_HEIGHT: cfg_height = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_rx_valid && !i_rx_stall) decode_byte(i_rx_byte);
        end
        pending_count = reports_due.size();
    end

endmodule

// ===== bench/tb_mouse_packet_decoder_top.sv =====
// Stimulus and verdict for the mouse packet decoder, checked by mpd_scoreboard.
`timescale 1ns / 1ps

module tb_mouse_packet_decoder_top;
    import mpd_pkg::*;

    localparam int COORD_BITS      = 12;
    localparam int SCROLL_BITS     = 16;
    localparam int CLK_HALF_NS     = 5;
    localparam int RESET_CYCLES    = 11;
    localparam int SETTLE_CYCLES   = 4;
    localparam int MAX_GAP         = 19;
    localparam int NUM_PHASES      = 10;
    localparam int BYTES_PER_PHASE = 50;
    localparam int DISABLED_BYTES  = 16;
    localparam int WIND_PACKETS    = 30;
    localparam int BURST_PACKETS   = 12;
    localparam int HOLD_CYCLES     = 300;
    localparam int TIMEOUT_NS      = 5_000_000;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;
    localparam logic [CFG_BITS-1:0]       LIMIT_MAX  = 12'hFFF;
    localparam logic [RX_BITS-1:0]        WHEEL_UP_ODD    = 8'h7F;
    localparam logic [RX_BITS-1:0]        WHEEL_DOWN_EVEN = 8'h80;

    typedef enum int {
        DRIFT_ANY  = 0,
        DRIFT_UP   = 1,
        DRIFT_DOWN = 2
    } t_drift;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [CFG_INDEX_BITS-1:0]     i_cfg_index;
    logic [CFG_BITS-1:0]           i_cfg_data;
    logic                          i_valid;
    logic                          o_stall;
    logic [RX_BITS-1:0]            i_rx_byte;
    logic                          o_valid;
    logic                          i_stall;
    logic [COORD_BITS-1:0]         o_pos_x;
    logic [COORD_BITS-1:0]         o_pos_y;
    logic                          o_button_left;
    logic                          o_button_right;
    logic                          o_button_middle;
    logic signed [SCROLL_BITS-1:0] o_wheel_x_total;
    logic signed [SCROLL_BITS-1:0] o_wheel_y_total;
    logic                          o_update_kind;

    int mismatches;
    int pending;

    bit tx_idle_on;
    bit rx_idle_on;
    bit rx_hold_req;

    always #CLK_HALF_NS i_clk = ~i_clk;

    mouse_packet_decoder_top #(
        .COORD_BITS  (COORD_BITS),
        .SCROLL_BITS (SCROLL_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_button_left   (o_button_left),
        .o_button_right  (o_button_right),
        .o_button_middle (o_button_middle),
        .o_wheel_x_total (o_wheel_x_total),
        .o_wheel_y_total (o_wheel_y_total),
        .o_update_kind   (o_update_kind)
    );

    mpd_scoreboard #(
        .COORD_BITS  (COORD_BITS),
        .SCROLL_BITS (SCROLL_BITS)
    ) u_scoreboard (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_rx_valid      (i_valid),
        .i_rx_stall      (o_stall),
        .i_rx_byte       (i_rx_byte),
        .i_res_valid     (o_valid),
        .i_res_stall     (i_stall),
        .i_pos_x         (o_pos_x),
        .i_pos_y         (o_pos_y),
        .i_button_left   (o_button_left),
        .i_button_right  (o_button_right),
        .i_button_middle (o_button_middle),
        .i_wheel_x_total (o_wheel_x_total),
        .i_wheel_y_total (o_wheel_y_total),
        .i_update_kind   (o_update_kind),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    function automatic int draw_gap(bit idle_on);
        return idle_on ? $urandom_range(0, MAX_GAP) : 0;
    endfunction

    function automatic logic [RX_BITS-1:0] draw_delta(t_drift d);
        case (d)
            DRIFT_UP:   return RX_BITS'($urandom_range(0, 127));
            DRIFT_DOWN: return RX_BITS'($urandom_range(128, 255));
            default:    return RX_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [CFG_BITS-1:0] pick_limit(int sel);
        case (sel % 4)
            0:       return LIMIT_MAX;
            1:       return '0;
            2:       return CFG_BITS'($urandom_range(0, 4095));
            default: return CFG_BITS'($urandom_range(1, 200));
        endcase
    endfunction

    task automatic send_byte(input logic [RX_BITS-1:0] b);
        int gap;
        gap = draw_gap(tx_idle_on);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_seq(input logic [RX_BITS-1:0] seq[$]);
        foreach (seq[k]) send_byte(seq[k]);
    endtask

    task automatic send_packet(input t_drift dx_d, input t_drift dy_d,
                               input logic [RX_BITS-1:0] wheel);
        logic [RX_BITS-1:0] hdr;
        hdr = RX_BITS'($urandom_range(0, 255));
        hdr[HEADER_SYNC_BIT] = 1'b1;
        send_byte(hdr);
        send_byte(draw_delta(dx_d));
        send_byte(draw_delta(dy_d));
        send_byte(wheel);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] index,
                             input logic [CFG_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // drop the request, wait for every result, then let the pipeline empty
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        #TIMEOUT_NS;
        $display("tb_mouse_packet_decoder_top: FAIL");
        $finish;
    end

    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            if (rx_hold_req) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end
            gap = draw_gap(rx_idle_on);
            if (gap > 0) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
        end
    end

    initial begin
        int     sent;
        t_drift dx_d;
        t_drift dy_d;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_ENABLE;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_rx_byte   = '0;
        i_stall     = 1'b0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        rx_hold_req = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // disabled after reset: these must leave no trace
        send_seq('{8'h08, 8'hFF});
        settle();
        cfg_write(CFG_ENABLE, 12'd1);
        cfg_write(CFG_WIDTH, LIMIT_MAX);
        cfg_write(CFG_HEIGHT, LIMIT_MAX);
        send_seq('{8'h07, 8'h00,
                   8'h0F, 8'h7F, 8'h80, 8'h01,
                   8'h09, 8'h80, 8'h7F, 8'hFE,
                   8'h0A, 8'h7F, 8'h00, 8'h7F,
                   8'h0C, 8'h7F, 8'h00, 8'h80});
        settle();
        // lower both limits below the current position
        cfg_write(CFG_WIDTH, 12'd100);
        cfg_write(CFG_HEIGHT, '0);
        send_seq('{8'h08, 8'h00, 8'h00, 8'h00});

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            tx_idle_on = (ph % 3) != 2;
            rx_idle_on = (ph % 4) != 3;
            cfg_write(CFG_UNUSED, CFG_BITS'($urandom_range(0, 4095)));
            cfg_write(CFG_WIDTH, pick_limit(ph));
            cfg_write(CFG_HEIGHT, pick_limit(ph + 2));
            if (ph == 4) begin
                cfg_write(CFG_ENABLE, '0);
                repeat (DISABLED_BYTES) send_byte(RX_BITS'($urandom_range(0, 255)));
                settle();
                cfg_write(CFG_ENABLE, 12'd1);
            end
            dx_d = t_drift'((ph + 1) % 3);
            dy_d = t_drift'((ph + 2) % 3);
            sent = 0;
            while (sent < BYTES_PER_PHASE) begin
                if ($urandom_range(0, 99) < 85) begin
                    send_packet(dx_d, dy_d, RX_BITS'($urandom_range(0, 255)));
                    sent += 4;
                end else begin
                    send_byte(RX_BITS'($urandom_range(0, 255)));
                    sent++;
                end
            end
        end

        // realign framing, then drive full-size scroll steps back to back
        send_seq('{8'h00, 8'h00, 8'h00});
        settle();
        cfg_write(CFG_WIDTH, LIMIT_MAX);
        cfg_write(CFG_HEIGHT, LIMIT_MAX);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (int k = 0; k < WIND_PACKETS; k++)
            send_packet(DRIFT_ANY, DRIFT_ANY, (k % 2) ? WHEEL_UP_ODD : WHEEL_DOWN_EVEN);

        // hold the result side off while requests keep coming
        rx_idle_on  = 1'b1;
        rx_hold_req = 1'b1;
        repeat (BURST_PACKETS)
            send_packet(DRIFT_ANY, DRIFT_ANY, RX_BITS'($urandom_range(0, 255)));

        settle();
        if (mismatches == 0 && pending == 0) begin
            $display("tb_mouse_packet_decoder_top: PASS");
        end else begin
            $display("tb_mouse_packet_decoder_top: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/mpd_pkg.sv
hdl/mpd_clamp.sv
hdl/mouse_packet_decoder_top.sv
bench/mpd_scoreboard.sv
bench/tb_mouse_packet_decoder_top.sv
